### hdl/bdac_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies; every other file of the block imports this package.
package bdac_pkg;

    localparam int BIN_WIDTH  = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int CNT_W      = $clog2(BIN_WIDTH);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    // ASCII '0' folded into the six-bit character field.
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
    localparam logic [DIGIT_W-1:0] DEC_MAX    = DIGIT_W'(9);
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } t_cell_op;

    // What one cell hands to its more significant neighbour.
    typedef struct packed {
        logic                carry;
        logic [DIGIT_W-1:0]  digit;
    } t_link;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

endpackage

### hdl/bdac_cell.sv
// One BCD digit cell of the conversion chain.
// Depends on bdac_pkg for the link struct and the cell operation codes.
module bdac_cell (
    input  logic              i_clk,
    input  bdac_pkg::t_cell_op i_op,
    input  bdac_pkg::t_link   i_link,
    output bdac_pkg::t_link   o_link
);
    import bdac_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] adj;

    // Add three to a digit of five or more so that the coming shift carries correctly.
    assign adj = (r_digit >= ADJ_LIMIT) ? (r_digit + ADJ_ADD) : r_digit;

    always_comb begin
        unique case (i_op)
            CELL_HOLD:   n_digit = r_digit;
            CELL_CLEAR:  n_digit = '0;
            CELL_DABBLE: n_digit = {adj[DIGIT_W-2:0], i_link.carry};
            CELL_SHIFT:  n_digit = i_link.digit;
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_link.carry = adj[DIGIT_W-1];
    assign o_link.digit = r_digit;

endmodule

### hdl/binary_to_decimal_ascii_core.sv
// Binary to decimal ASCII converter: top level with control and the digit cell chain.
// Depends on bdac_pkg and bdac_cell.
// Sequence: a value is taken while the controller is idle, converted by the 32
// shift-and-add steps, then emitted one digit position at a time, leading zero digits skipped.
// A new value is taken only after the units digit of the last one has been sent, and
// a stalled output holds the emission.
// Reset (synchronous, active low) returns the controller to idle and drops o_valid.
module binary_to_decimal_ascii_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bdac_pkg::BIN_WIDTH-1:0] i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bdac_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                           o_last
);
    import bdac_pkg::*;

    // The chain holds ten BCD digits, cell zero the least significant. While
    // converting, each cell adds three where needed and shifts left by one bit,
    // taking the top bit of the binary shift register into cell zero. While
    // emitting, the whole chain shifts up by one digit each cycle unless a digit to be
    // sent waits on a stalled output, so that the top cell always presents the next character.

    t_state              r_state;
    t_state              n_state;
    logic [BIN_WIDTH-1:0] r_bin;
    logic [CNT_W-1:0]    r_cnt;
    logic [LEFT_W-1:0]   r_left;
    logic                r_lead;
    logic                r_ovalid;
    logic [CHAR_W-1:0]   r_ochar;
    logic                r_olast;

    t_cell_op            cell_op;
    t_link               link_in  [NUM_DIGITS];
    t_link               link_out [NUM_DIGITS];

    logic                in_beat;
    logic                out_free;
    logic                conv_done;
    logic                emit_now;
    logic                skip_now;
    logic                final_digit;
    logic [DIGIT_W-1:0]  top_digit;

    assign in_beat     = i_valid && !o_stall;
    assign out_free    = !r_ovalid || !i_stall;
    assign conv_done   = (r_cnt == CNT_W'(BIN_WIDTH - 1));
    assign top_digit   = link_out[NUM_DIGITS-1].digit;
    assign final_digit = (r_left == LEFT_W'(1));
    // A leading zero is dropped without a beat; the units digit is always sent.
    assign skip_now    = (r_state == ST_EMIT) && (top_digit == '0) && !r_lead
                         && !final_digit;
    assign emit_now    = (r_state == ST_EMIT) && !skip_now && out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_now && final_digit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_stall = 1'b1;
        cell_op = CELL_HOLD;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                cell_op = CELL_CLEAR;
            end
            ST_CONV: begin
                cell_op = CELL_DABBLE;
            end
            ST_EMIT: begin
                if (skip_now || emit_now) begin
                    cell_op = CELL_SHIFT;
                end
            end
            default: begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    // Cell chain.
    assign link_in[0].carry = r_bin[BIN_WIDTH-1];
    assign link_in[0].digit = '0;

    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
        if (g > 0) begin : g_link
            assign link_in[g] = link_out[g-1];
        end
        bdac_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (cell_op),
            .i_link (link_in[g]),
            .o_link (link_out[g])
        );
    end

    // Sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_now) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_bin <= i_value;
            r_cnt <= '0;
        end else if (r_state == ST_CONV) begin
            r_bin <= {r_bin[BIN_WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (r_state == ST_CONV) begin
            r_left <= LEFT_W'(NUM_DIGITS);
            r_lead <= 1'b0;
        end else if (skip_now || emit_now) begin
            r_left <= r_left - LEFT_W'(1);
            if (emit_now) begin
                r_lead <= 1'b1;
            end
        end
        if (emit_now) begin
            r_ochar <= ASCII_ZERO + CHAR_W'(top_digit);
            r_olast <= final_digit;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_digit_char = r_ochar;
    assign o_last       = r_olast;

    // Ten digits always hold a 32-bit value, so nothing leaves the top cell.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !link_out[NUM_DIGITS-1].carry)
        else $error("carry left the most significant digit cell");

    // Every character sent is a decimal digit.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_char >= ASCII_ZERO)
                    && (o_digit_char <= ASCII_ZERO + CHAR_W'(DEC_MAX)))
        else $error("character outside the decimal digits");

    // The digit budget never runs out while emitting.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_left != '0))
        else $error("digit count ran out during emission");

    // Once the final digit is loaded, emission for that value has ended.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_now && final_digit) |=> (r_state == ST_IDLE) && o_last)
        else $error("emission carried on after the final digit");

endmodule

### dv/bdac_checker.sv
`timescale 1ns / 1ps
// Checker for the binary to decimal ASCII converter: predicts the digit beats of each value.
// Watches both channels of binary_to_decimal_ascii_core; needs bdac_pkg for widths.
module bdac_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_value_valid,
    input  logic                           i_value_stall,
    input  logic [bdac_pkg::BIN_WIDTH-1:0] i_value,
    input  logic                           i_char_valid,
    input  logic                           i_char_stall,
    input  logic [bdac_pkg::CHAR_W-1:0]    i_digit_char,
    input  logic                           i_last,
    output int                             o_mismatch_count,
    output int                             o_chars_pending
);

    import bdac_pkg::*;

    localparam int unsigned DEC_BASE = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_char_beat;

    t_char_beat expected_chars[$];

    initial begin
        o_mismatch_count = 0;
        o_chars_pending  = 0;
    end

    // Queues the decimal text of one value, most significant digit first.
    function automatic void queue_decimal_text(input logic [BIN_WIDTH-1:0] value);
        logic [DIGIT_W-1:0]   digits [NUM_DIGITS];
        logic [BIN_WIDTH-1:0] rest;
        int                   count;
        t_char_beat           beat;
        rest  = value;
        count = 0;
        do begin
            digits[count] = DIGIT_W'(rest % DEC_BASE);
            rest          = rest / DEC_BASE;
            count++;
        end while (rest != 0);
        for (int k = count - 1; k >= 0; k--) begin
            beat.digit_char = ASCII_ZERO + CHAR_W'(digits[k]);
            beat.last       = (k == 0);
            expected_chars.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n) begin
            // Compare before predicting: a character can never belong to a value taken
            // at the same edge.
            if (i_char_valid && !i_char_stall) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character beat: digit_char %0d last %0d",
                           i_digit_char, i_last);
                    o_mismatch_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (i_digit_char !== want.digit_char) begin
                        $error("digit_char mismatch: expected %0d, actual %0d",
                               want.digit_char, i_digit_char);
                        o_mismatch_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d", want.last, i_last);
                        o_mismatch_count++;
                    end
                end
            end
            if (i_value_valid && !i_value_stall) begin
                queue_decimal_text(i_value);
            end
            o_chars_pending = expected_chars.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the testbench for binary_to_decimal_ascii_core: clock, reset, stimulus and verdict.
// Depends on bdac_pkg, the core itself and bdac_checker, which does all the checking.
module tb_top;

    import bdac_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RANDOM_FIRST  = 120;
    localparam int RANDOM_SECOND = 120;
    localparam int RANDOM_THIRD  = 110;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [BIN_WIDTH-1:0] i_value;
    logic                 o_valid;
    logic                 i_stall;
    logic [CHAR_W-1:0]    o_digit_char;
    logic                 o_last;

    int mismatch_count;
    int chars_pending;
    int cycle_count;

    // Idle rates in percent, changed per phase by the stimulus process.
    int send_idle_pct;
    int recv_idle_pct;

    // Raised by the stimulus process to ask the receiver for one long hold-off;
    // the receiver drops it again once the stretch is over.
    logic hold_req;

    binary_to_decimal_ascii_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    bdac_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_value_valid    (i_valid),
        .i_value_stall    (o_stall),
        .i_value          (i_value),
        .i_char_valid     (o_valid),
        .i_char_stall     (i_stall),
        .i_digit_char     (o_digit_char),
        .i_last           (o_last),
        .o_mismatch_count (mismatch_count),
        .o_chars_pending  (chars_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // Watchdog: a stuck handshake or a lost character ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: stalls the character channel at random on each falling edge, or holds it
    // off for a long stretch when asked, so that the core fills up and stalls its input.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Offers one value and returns at the falling edge after it has been taken. It is
    // always entered at a falling edge, so valid is only ever assigned once per step:
    // either dropped for an idle cycle or kept high with the next value.
    task automatic send_value(input logic [BIN_WIDTH-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // Mostly values of a random decimal length, so that every digit count from one to ten
    // is well represented; the rest are raw 32-bit words, which favour ten digits.
    function automatic logic [BIN_WIDTH-1:0] pick_value();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned raw;
        int              len;
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        len = $urandom_range(1, NUM_DIGITS);
        lo  = 1;
        for (int k = 1; k < len; k++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (len == 1) lo = 0;
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        raw = $urandom;
        return BIN_WIDTH'(lo + raw % (hi - lo + 1));
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_value(pick_value());
        end
    endtask

    // Drops valid and waits until every queued character has come out.
    task automatic pause_sender();
        i_valid <= 1'b0;
        wait (chars_pending == 0);
        @(negedge i_clk);
    endtask

    // Directed values: zero, the single and double digit edges, the power of ten
    // boundaries at 10, 100, 1000, 10^7 and 10^9, and bit patterns that toggle every input bit.
    logic [BIN_WIDTH-1:0] directed_values[] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
        32'd9999999, 32'd10000000, 32'd999999999, 32'd1000000000,
        32'd1234567890, 32'd4294967290, 32'd4294967294, 32'd4294967295,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
        32'd0, 32'd5
    };

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_value       = '0;
        hold_req      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: a sender that rarely idles against a receiver that often stalls.
        send_idle_pct = 11;
        recv_idle_pct = 55;
        foreach (directed_values[i]) begin
            send_value(directed_values[i]);
        end
        send_random(20);
        // The long hold-off starts while the sender keeps offering values.
        hold_req = 1'b1;
        send_random(RANDOM_FIRST - 20);
        pause_sender();

        // Phase two: the roles swapped, a lazy sender and an eager receiver.
        send_idle_pct = 55;
        recv_idle_pct = 11;
        send_random(RANDOM_SECOND);
        pause_sender();

        // Phase three: neither side idles, so values arrive back to back.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(RANDOM_THIRD);
        i_valid <= 1'b0;

        wait (chars_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### files.f
hdl/bdac_pkg.sv
hdl/bdac_cell.sv
hdl/binary_to_decimal_ascii_core.sv
dv/bdac_checker.sv
dv/tb_top.sv
